// File: rtl/bhps_pkg.sv
// package for the ball height pid servo: widths, constants, shared types
// and the microcode rom of the sequencer
// no dependencies
package bhps_pkg;

    // default column length in cm, legal range 10 to 200
    localparam int COLUMN_LENGTH_CM_DEF = 75;

    // field widths
    localparam int ECHO_W     = 13;
    localparam int HEIGHT_W   = 13;
    localparam int GAIN_W     = 16;
    localparam int ANGLE_W    = 7;
    localparam int DRIVE_W    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // datapath widths; raw height covers columns up to 200 cm
    localparam int RAW_W   = 19;
    localparam int ERR_W   = 14;
    localparam int MUL_W   = 21;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 42;
    localparam int INTEG_W = 32;
    localparam int NUM_W   = 19;

    // divide by 10 and by 5000 as reciprocal multiplies, exact for the ranges used
    localparam int RECIP10        = 209716;
    localparam int RECIP10_SHIFT  = 21;
    localparam int RECIP5000      = 858994;
    localparam int RECIP5000_SHIFT = 32;

    // control output constants, sums are in 1/256 of 0.01 percent
    localparam int BIAS_SUM   = 5000 * 256;
    localparam int SAT_SUM    = 10000 * 256;
    localparam int DRIVE_MAX  = 10000;
    localparam int DRIVE_MID  = 5000;
    localparam int DRIVE_TOP  = 2000;
    localparam int ANGLE_MAX  = 90;
    localparam int ANGLE_DIV  = 5000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET  = 3'd0,
        REG_KP      = 3'd1,
        REG_KI      = 3'd2,
        REG_KD      = 3'd3,
        REG_BALANCE = 3'd4
    } t_reg;

    // datapath operations
    typedef enum logic [3:0] {
        OP_RAW     = 4'd0,
        OP_DIV10   = 4'd1,
        OP_HEIGHT  = 4'd2,
        OP_ERR     = 4'd3,
        OP_MUL_I   = 4'd4,
        OP_INTEG   = 4'd5,
        OP_MUL_P   = 4'd6,
        OP_MUL_D   = 4'd7,
        OP_ADD     = 4'd8,
        OP_CLAMP   = 4'd9,
        OP_MUL_ANG = 4'd10,
        OP_NUM     = 4'd11,
        OP_MUL_Q   = 4'd12,
        OP_ANGLE   = 4'd13,
        OP_HOLD    = 4'd14
    } t_op;

    // sequencing of a control word
    typedef enum logic [1:0] {
        JC_NEXT = 2'd0,
        JC_HOLD = 2'd1,
        JC_END  = 2'd2
    } t_jc;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_HOLD = 4'd14;

    typedef struct packed {
        t_op             op;
        t_jc             jc;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic en;
        t_op  op;
    } t_dp_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_status;

    typedef struct packed {
        logic [HEIGHT_W-1:0] target;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   kd;
        logic [ANGLE_W-1:0]  balance;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_W-1:0]  angle;
        logic [DRIVE_W-1:0]  drive;
        logic [HEIGHT_W-1:0] height;
        logic                fault;
        logic                top;
    } t_result;

    // microcode program, one control word per step
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w.target = '0;
        w.jc     = JC_NEXT;
        case (pc)
            4'd0: begin
                w.op     = OP_RAW;
                w.jc     = JC_HOLD;
                w.target = STEP_HOLD;
            end
            4'd1:  w.op = OP_DIV10;
            4'd2:  w.op = OP_HEIGHT;
            4'd3:  w.op = OP_ERR;
            4'd4:  w.op = OP_MUL_I;
            4'd5:  w.op = OP_INTEG;
            4'd6:  w.op = OP_MUL_P;
            4'd7:  w.op = OP_MUL_D;
            4'd8:  w.op = OP_ADD;
            4'd9:  w.op = OP_CLAMP;
            4'd10: w.op = OP_MUL_ANG;
            4'd11: w.op = OP_NUM;
            4'd12: w.op = OP_MUL_Q;
            4'd13: begin
                w.op = OP_ANGLE;
                w.jc = JC_END;
            end
            default: begin
                w.op = OP_HOLD;
                w.jc = JC_END;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/bhps_seq.sv
// microcode sequencer: step counter, rom lookup, hold jump and end of program
// depends on bhps_pkg
module bhps_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_hold,
    input  logic                  i_out_full,
    output bhps_pkg::t_dp_ctl     o_ctl,
    output bhps_pkg::t_seq_status o_status
);

    logic                        r_busy, n_busy;
    logic [bhps_pkg::PC_W-1:0]   r_pc, n_pc;
    bhps_pkg::t_uword            uw;
    logic                        step_en;

    always_comb begin
        uw      = bhps_pkg::ucode_rom(r_pc);
        // the final step waits while the output register still holds an item
        step_en = r_busy && !(uw.jc == bhps_pkg::JC_END && i_out_full);
        n_busy  = r_busy;
        n_pc    = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else if (step_en) begin
            case (uw.jc)
                bhps_pkg::JC_END:  n_busy = 1'b0;
                bhps_pkg::JC_HOLD: n_pc   = i_hold ? uw.target : r_pc + 1'b1;
                default:           n_pc   = r_pc + 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ctl.en        = step_en;
    assign o_ctl.op        = uw.op;
    assign o_status.busy   = r_busy;
    assign o_status.done   = step_en && (uw.jc == bhps_pkg::JC_END);

endmodule

// File: rtl/bhps_dp.sv
// datapath: height conversion, pid sum with one shared multiplier,
// clamping with integral hold and the angle mapping; depends on bhps_pkg
module bhps_dp #(
    parameter int COLUMN_LENGTH_CM = bhps_pkg::COLUMN_LENGTH_CM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bhps_pkg::t_dp_ctl                 i_ctl,
    input  bhps_pkg::t_cfg                    i_cfg,
    input  logic [bhps_pkg::ECHO_W-1:0]       i_echo,
    output bhps_pkg::t_result                 o_result
);

    localparam int RAW_W   = bhps_pkg::RAW_W;
    localparam int ACC_W   = bhps_pkg::ACC_W;
    localparam int MUL_W   = bhps_pkg::MUL_W;
    localparam int PROD_W  = bhps_pkg::PROD_W;
    localparam int H_W     = bhps_pkg::HEIGHT_W;
    localparam int ERR_W   = bhps_pkg::ERR_W;
    localparam int IW      = bhps_pkg::INTEG_W;
    localparam int D_W     = bhps_pkg::DRIVE_W;
    localparam int A_W     = bhps_pkg::ANGLE_W;
    localparam int TOP_W   = 15;

    localparam logic signed [RAW_W-1:0] RAW_BASE = RAW_W'((COLUMN_LENGTH_CM - 1) * 1000);
    localparam logic signed [RAW_W-1:0] RAW_MAX  = RAW_W'(COLUMN_LENGTH_CM * 1000);
    localparam logic [TOP_W-1:0]        TOP_LIM  = TOP_W'((COLUMN_LENGTH_CM - 5) * 100);
    localparam logic signed [ACC_W-1:0] BIAS     = ACC_W'(bhps_pkg::BIAS_SUM);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(bhps_pkg::SAT_SUM);
    localparam int H_LO = bhps_pkg::RECIP10_SHIFT;
    localparam int Q_LO = bhps_pkg::RECIP5000_SHIFT;

    // state
    logic [H_W-1:0]            r_held;
    logic signed [IW-1:0]      r_integ;

    // working registers
    logic signed [RAW_W-1:0]   r_raw;
    logic                      r_fault;
    logic signed [PROD_W-1:0]  r_prod;
    logic [H_W-1:0]            r_height;
    logic [H_W-1:0]            r_prev;
    logic                      r_top;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_dh;
    logic signed [IW-1:0]      r_integ_new;
    logic signed [ACC_W-1:0]   r_acc;
    logic [D_W-1:0]            r_drive;

    logic [RAW_W-2:0]          echo_x17;
    logic signed [RAW_W-1:0]   raw_c;
    logic                      fault_c;
    logic [H_W-1:0]            height_c;
    logic signed [IW:0]        integ_sum_c;
    logic signed [IW-1:0]      integ_sat_c;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic [A_W-1:0]            ang_b;
    logic                      ang_hi;
    logic [D_W-1:0]            ang_x;
    logic [A_W-1:0]            ang_k;

    // raw height times ten: (length-1)*1000 - 17*echo
    assign echo_x17 = (RAW_W-1)'({i_echo, 4'b0000}) + (RAW_W-1)'(i_echo);
    assign raw_c    = RAW_BASE - $signed({1'b0, echo_x17});
    assign fault_c  = (i_echo == '0) || raw_c[RAW_W-1] || (raw_c > RAW_MAX);

    assign height_c = r_fault ? r_held : r_prod[H_LO+H_W-1:H_LO];

    // integral with 32 bit saturation
    assign integ_sum_c = (IW+1)'(r_integ) + (IW+1)'(r_prod);
    always_comb begin
        if (integ_sum_c[IW] != integ_sum_c[IW-1])
            integ_sat_c = integ_sum_c[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        else
            integ_sat_c = integ_sum_c[IW-1:0];
    end

    // angle mapping pieces, balance limited to ninety degrees
    always_comb begin
        ang_b  = (i_cfg.balance > A_W'(bhps_pkg::ANGLE_MAX)) ?
                 A_W'(bhps_pkg::ANGLE_MAX) : i_cfg.balance;
        ang_hi = r_drive >= D_W'(bhps_pkg::DRIVE_MID);
        ang_x  = ang_hi ? r_drive - D_W'(bhps_pkg::DRIVE_MID) : r_drive;
        ang_k  = ang_hi ? A_W'(bhps_pkg::ANGLE_MAX) - ang_b : ang_b;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctl.op)
            bhps_pkg::OP_DIV10: begin
                mul_a = MUL_W'(r_raw[RAW_W-2:0]);
                mul_b = MUL_W'(bhps_pkg::RECIP10);
            end
            bhps_pkg::OP_MUL_I: begin
                mul_a = MUL_W'(i_cfg.ki);
                mul_b = MUL_W'(r_err);
            end
            bhps_pkg::OP_MUL_P: begin
                mul_a = MUL_W'(i_cfg.kp);
                mul_b = MUL_W'(r_err);
            end
            bhps_pkg::OP_MUL_D: begin
                mul_a = MUL_W'(i_cfg.kd);
                mul_b = MUL_W'(r_dh);
            end
            bhps_pkg::OP_MUL_ANG: begin
                mul_a = MUL_W'(ang_x);
                mul_b = MUL_W'(ang_k);
            end
            bhps_pkg::OP_MUL_Q: begin
                mul_a = MUL_W'(r_acc[bhps_pkg::NUM_W-1:0]);
                mul_b = MUL_W'(bhps_pkg::RECIP5000);
            end
            default: ;
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_integ <= '0;
        end else if (i_ctl.en) begin
            if (i_ctl.op == bhps_pkg::OP_HEIGHT && !r_fault)
                r_held <= height_c;
            // integral holds when the sum clamps
            if (i_ctl.op == bhps_pkg::OP_CLAMP && !(r_acc > SAT_HI) && !r_acc[ACC_W-1])
                r_integ <= r_integ_new;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= prod_c;
            case (i_ctl.op)
                bhps_pkg::OP_RAW: begin
                    r_raw   <= raw_c;
                    r_fault <= fault_c;
                end
                bhps_pkg::OP_HEIGHT: begin
                    r_height <= height_c;
                    r_prev   <= r_held;
                    r_top    <= TOP_W'(height_c) > TOP_LIM;
                end
                bhps_pkg::OP_ERR: begin
                    r_err <= $signed({1'b0, i_cfg.target}) - $signed({1'b0, r_height});
                    r_dh  <= $signed({1'b0, r_prev}) - $signed({1'b0, r_height});
                end
                bhps_pkg::OP_INTEG:  r_integ_new <= integ_sat_c;
                bhps_pkg::OP_MUL_P:  r_acc <= BIAS + ACC_W'(r_integ_new);
                bhps_pkg::OP_MUL_D,
                bhps_pkg::OP_ADD,
                bhps_pkg::OP_NUM:    r_acc <= r_acc + ACC_W'(r_prod);
                bhps_pkg::OP_CLAMP: begin
                    if (r_top)
                        r_drive <= D_W'(bhps_pkg::DRIVE_TOP);
                    else if (r_acc > SAT_HI)
                        r_drive <= D_W'(bhps_pkg::DRIVE_MAX);
                    else if (r_acc[ACC_W-1])
                        r_drive <= '0;
                    else
                        r_drive <= r_acc[D_W+7:8];
                end
                bhps_pkg::OP_MUL_ANG: begin
                    // offset of the upper segment: 5000 times balance
                    r_acc <= ang_hi ? ACC_W'(ang_b) * ACC_W'(bhps_pkg::ANGLE_DIV) : '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_ctl.op == bhps_pkg::OP_HOLD) begin
            o_result        = '0;
            o_result.height = r_held;
        end else begin
            o_result.angle  = r_prod[Q_LO+A_W-1:Q_LO];
            o_result.drive  = r_drive;
            o_result.height = r_height;
            o_result.fault  = r_fault;
            o_result.top    = r_top;
        end
    end

endmodule

// File: rtl/ball_height_pid_servo.sv
// top level of the ball height pid servo: stream ports, configuration
// registers, input capture and output register; uses bhps_pkg, bhps_seq, bhps_dp
//
// one item at a time; a normal item runs the 14 step microcode program through one
//   shared multiplier, one step per cycle; the last step waits while output is full;
//   a hold item jumps from step 0 straight to the hold step and ends there
// reset: synchronous active low i_rst_n; registers return to their defaults,
//   held height and integral clear, no output item pending
module ball_height_pid_servo #(
    parameter int COLUMN_LENGTH_CM = bhps_pkg::COLUMN_LENGTH_CM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bhps_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [12:0] echo_time
    input  logic                                s_axis_tuser,  // [0] hold_closed
    // result item stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [6:0] servo_angle, [20:7] drive_level, [33:21] ball_height
    output logic [bhps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] sensor_fault, [1] near_top
    output logic [bhps_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [bhps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bhps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bhps_pkg::t_cfg                    r_cfg;
    logic [bhps_pkg::ECHO_W-1:0]       r_echo;
    logic                              r_hold;
    logic                              r_m_valid, n_m_valid;
    bhps_pkg::t_result                 r_out;

    bhps_pkg::t_dp_ctl                 dp_ctl;
    bhps_pkg::t_seq_status             seq_status;
    bhps_pkg::t_result                 result;
    logic                              in_accept;

    // one item in flight; the output register lets a new item start
    // while the previous result waits
    assign s_axis_tready = !seq_status.busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // configuration registers, unused indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target  <= '0;
            r_cfg.kp      <= bhps_pkg::GAIN_W'(179);
            r_cfg.ki      <= '0;
            r_cfg.kd      <= bhps_pkg::GAIN_W'(8192);
            r_cfg.balance <= bhps_pkg::ANGLE_W'(34);
        end else if (i_cfg_we) begin
            case (bhps_pkg::t_reg'(i_cfg_index))
                bhps_pkg::REG_TARGET:  r_cfg.target  <= i_cfg_data[bhps_pkg::HEIGHT_W-1:0];
                bhps_pkg::REG_KP:      r_cfg.kp      <= i_cfg_data;
                bhps_pkg::REG_KI:      r_cfg.ki      <= i_cfg_data;
                bhps_pkg::REG_KD:      r_cfg.kd      <= i_cfg_data;
                bhps_pkg::REG_BALANCE: r_cfg.balance <= i_cfg_data[bhps_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_echo <= s_axis_tdata[bhps_pkg::ECHO_W-1:0];
            r_hold <= s_axis_tuser;
        end
    end

    bhps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_hold     (r_hold),
        .i_out_full (r_m_valid && !m_axis_tready),
        .o_ctl      (dp_ctl),
        .o_status   (seq_status)
    );

    bhps_dp #(
        .COLUMN_LENGTH_CM (COLUMN_LENGTH_CM)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (dp_ctl),
        .i_cfg    (r_cfg),
        .i_echo   (r_echo),
        .o_result (result)
    );

    // output register, loaded at the last microcode step
    always_comb begin
        n_m_valid = r_m_valid;
        if (seq_status.done)
            n_m_valid = 1'b1;
        else if (m_axis_tready)
            n_m_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_m_valid <= 1'b0;
        else
            r_m_valid <= n_m_valid;
    end

    always_ff @(posedge i_clk) begin
        if (seq_status.done)
            r_out <= result;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_out.height, r_out.drive, r_out.angle};
    assign m_axis_tuser  = {r_out.top, r_out.fault};

endmodule

// File: rtl/bhps_checker.sv
// port level checks for the ball height pid servo and the bind that attaches them
// depends on bhps_pkg and the ports of ball_height_pid_servo
module bhps_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [bhps_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input logic                                s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [bhps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic [bhps_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    // no result pending and ready for input right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("outputs not idle after reset");

    // one item at a time: an accepted item blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // drive and angle stay in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:7] <= 14'd10000 && m_axis_tdata[6:0] <= 7'd90)
        else $error("drive or angle out of range");

    // near the top the drive is forced, also when a held height is reused
    a_near_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[20:7] == 14'd2000)
        else $error("near top without forced drive");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind ball_height_pid_servo bhps_checker u_bhps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/bhps_tb_pkg.sv
// scoreboard for the ball height pid servo bench: predicts each result item
// from its own copy of the registers, held height and integral, then checks
// depends on bhps_pkg for widths, register indexes and the result layout
`timescale 1ns / 100ps

package bhps_tb_pkg;

    import bhps_pkg::*;

    localparam int COLUMN_CM = COLUMN_LENGTH_CM_DEF;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    class servo_scoreboard;

        longint target_height;
        longint prop_gain;
        longint integ_gain;
        longint deriv_gain;
        longint balance_angle;
        longint held_height;
        longint integral_sum;

        t_result expected_results[$];
        int      mismatches;
        int      results_seen;

        function new();
            target_height = 0;
            prop_gain     = 179;
            integ_gain    = 0;
            deriv_gain    = 8192;
            balance_angle = 34;
            held_height   = 0;
            integral_sum  = 0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_TARGET:  target_height = value[HEIGHT_W-1:0];
                REG_KP:      prop_gain     = value[GAIN_W-1:0];
                REG_KI:      integ_gain    = value[GAIN_W-1:0];
                REG_KD:      deriv_gain    = value[GAIN_W-1:0];
                REG_BALANCE: balance_angle = value[ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip_int32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // piecewise linear map, balance point at half drive
        function longint drive_to_degrees(longint x);
            longint b;
            longint hund;
            b = (balance_angle > ANGLE_MAX) ? ANGLE_MAX : balance_angle;
            if (x < DRIVE_MID)
                hund = (x * 100 * b) / ANGLE_DIV;
            else
                hund = 100 * b + ((x - DRIVE_MID) * (ANGLE_MAX * 100 - 100 * b)) / ANGLE_DIV;
            return hund / 100;
        endfunction

        function t_result predict_step(logic [ECHO_W-1:0] echo, logic hold);
            t_result r;
            longint  raw10;
            longint  hgt;
            longint  prev;
            longint  err;
            longint  integ_new;
            longint  total;
            longint  drive;
            longint  deg;
            bit      fault;
            bit      top;
            r = '0;
            if (hold) begin
                r.height = held_height[HEIGHT_W-1:0];
                return r;
            end
            prev  = held_height;
            raw10 = longint'(COLUMN_CM - 1) * 1000 - 17 * longint'(echo);
            fault = (echo == 0) || (raw10 < 0) || (raw10 > longint'(COLUMN_CM) * 1000);
            if (fault) begin
                hgt = prev;
            end else begin
                hgt = (raw10 / 10) & 64'h1FFF;
                held_height = hgt;
            end
            err       = target_height - hgt;
            integ_new = clip_int32(integral_sum + integ_gain * err);
            total     = BIAS_SUM + prop_gain * err + deriv_gain * (prev - hgt) + integ_new;
            // clamp with integral hold on either rail
            if (total > SAT_SUM) begin
                drive = DRIVE_MAX;
            end else if (total < 0) begin
                drive = 0;
            end else begin
                drive = total >>> 8;
                integral_sum = integ_new;
            end
            top = hgt > longint'(COLUMN_CM - 5) * 100;
            if (top)
                drive = DRIVE_TOP;
            deg      = drive_to_degrees(drive);
            r.angle  = deg[ANGLE_W-1:0];
            r.drive  = drive[DRIVE_W-1:0];
            r.height = hgt[HEIGHT_W-1:0];
            r.fault  = fault;
            r.top    = top;
            return r;
        endfunction

        function void note_sample(logic [ECHO_W-1:0] echo, logic hold);
            expected_results.push_back(predict_step(echo, hold));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_result want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report("result item with nothing outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (data[6:0] !== want.angle)
                report($sformatf("servo_angle %0d, want %0d", data[6:0], want.angle));
            if (data[20:7] !== want.drive)
                report($sformatf("drive_level %0d, want %0d", data[20:7], want.drive));
            if (data[33:21] !== want.height)
                report($sformatf("ball_height %0d, want %0d", data[33:21], want.height));
            if (user[0] !== want.fault)
                report($sformatf("sensor_fault %b, want %b", user[0], want.fault));
            if (user[1] !== want.top)
                report($sformatf("near_top %b, want %b", user[1], want.top));
        endtask

    endclass

endpackage

// File: tb/sv/tb_top.sv
// top level bench for the ball height pid servo: clock, reset, stream drivers,
// configuration writes, random idling and the end of run decision
// depends on bhps_pkg, bhps_tb_pkg and the ball_height_pid_servo rtl
`timescale 1ns / 100ps

module tb_top;

    import bhps_pkg::*;
    import bhps_tb_pkg::*;

    // run limit, several times the slowest legal run
    localparam int LIMIT_CYCLES  = 1000000;
    // quiet cycles after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 180;

    // last echo that still gives a height inside the column
    localparam int ECHO_LAST_VALID = ((COLUMN_CM - 1) * 1000) / 17;
    // last echo that lands above the near top line
    localparam int ECHO_NEAR_TOP   = ((COLUMN_CM - 1) * 1000 - (COLUMN_CM - 5) * 1000 - 10) / 17;
    localparam int ECHO_MAX        = (1 << ECHO_W) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [12:0] echo_time
    logic                  s_axis_tuser;   // [0] hold_closed
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [6:0] servo_angle, [20:7] drive_level, [33:21] ball_height
    logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] sensor_fault, [1] near_top
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    servo_scoreboard sb;

    // idling controls shared between the stimulus and the receiver
    bit tx_steady;
    bit rx_steady;
    int rx_hold_cycles;
    int cycle_count;

    ball_height_pid_servo u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    // one register write, noted in the scoreboard at the edge that takes it
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.load_register(idx, value[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_all(input int target, input int kp, input int ki, input int kd,
                           input int balance);
        set_register(REG_TARGET, target);
        set_register(REG_KP, kp);
        set_register(REG_KI, ki);
        set_register(REG_KD, kd);
        set_register(REG_BALANCE, balance);
    endtask

    // offer one item and hold it until taken, then maybe leave a gap
    task automatic send_sample(input int echo, input bit hold);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, echo[ECHO_W-1:0]};
        s_axis_tuser  = hold;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_sample(echo[ECHO_W-1:0], hold);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // drop valid, let every result drain, then give the sequencer time to park
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random settings, extremes picked often
    task automatic random_settings();
        int target;
        int kp;
        int ki;
        int kd;
        int balance;
        case ($urandom_range(0, 3))
            0:       target = 0;
            1:       target = 7500;
            default: target = $urandom_range(500, 7000);
        endcase
        case ($urandom_range(0, 7))
            0:       kp = 0;
            1:       kp = 65535;
            default: kp = $urandom_range(0, 1024);
        endcase
        case ($urandom_range(0, 7))
            0:       ki = 0;
            1:       ki = 65535;
            default: ki = $urandom_range(0, 64);
        endcase
        case ($urandom_range(0, 7))
            0:       kd = 0;
            1:       kd = 65535;
            default: kd = $urandom_range(0, 1024);
        endcase
        case ($urandom_range(0, 5))
            0:       balance = 0;
            1:       balance = 90;
            2:       balance = $urandom_range(91, 127);
            default: balance = $urandom_range(0, 90);
        endcase
        set_all(target, kp, ki, kd, balance);
    endtask

    // mostly a ball hovering around the target, with dropouts, bad echoes
    // and startup holds mixed in
    task automatic send_random_item();
        int r;
        int h;
        int off;
        int echo;
        bit hold;
        r    = $urandom_range(0, 99);
        hold = 1'b0;
        if (r < 5) begin
            hold = 1'b1;
            echo = $urandom_range(0, ECHO_MAX);
        end else if (r < 10) begin
            echo = 0;
        end else if (r < 15) begin
            echo = $urandom_range(ECHO_LAST_VALID + 1, ECHO_MAX);
        end else if (r < 30) begin
            echo = $urandom_range(1, ECHO_LAST_VALID);
        end else begin
            off = $urandom_range(0, 600);
            h   = int'(sb.target_height) + off - 300;
            if (h < 1)
                h = 1;
            if (h > (COLUMN_CM - 1) * 100 - 2)
                h = (COLUMN_CM - 1) * 100 - 2;
            echo = ((COLUMN_CM - 1) * 1000 - h * 10) / 17;
            if (echo < 1)
                echo = 1;
            if (echo > ECHO_LAST_VALID)
                echo = ECHO_LAST_VALID;
        end
        send_sample(echo, hold);
    endtask

    // result side: check every item taken
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // receiver: random stalls, steady stretches, and the long hold-off that
    // backs the block up into its input
    initial begin : rx_side
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready  = 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left    = stall_left - 1;
            end else begin
                m_axis_tready = 1'b1;
                if (!rx_steady)
                    stall_left = pick_gap();
            end
        end
    end

    // run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int n;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rx_hold_cycles = 0;
        sb             = new();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: hold before any good height, dropouts, range edges
        send_sample(0, 1'b1);
        send_sample(0, 1'b0);
        send_sample(1, 1'b0);
        send_sample(ECHO_NEAR_TOP, 1'b0);
        send_sample(ECHO_NEAR_TOP + 1, 1'b0);
        send_sample(ECHO_LAST_VALID, 1'b0);
        send_sample(ECHO_LAST_VALID + 1, 1'b0);
        send_sample(ECHO_MAX, 1'b0);
        send_sample(ECHO_MAX, 1'b1);
        send_sample(13'h1555, 1'b0);
        send_sample(13'h0AAA, 1'b0);
        wait_idle();

        // ball far below target with a huge gain: upper rail, balance above ninety,
        // writes past the last register must change nothing
        set_all(7500, 65535, 0, 0, 127);
        set_register(REG_SPARE_FIRST, 'hFFFF);
        set_register(REG_SPARE_LAST, 0);
        send_sample(3000, 1'b0);
        send_sample(4000, 1'b0);
        send_sample(ECHO_NEAR_TOP, 1'b0);
        send_sample(2000, 1'b1);
        wait_idle();

        // ball above target: lower rail, zero balance angle
        set_all(0, 65535, 65535, 65535, 0);
        send_sample(1000, 1'b0);
        send_sample(ECHO_LAST_VALID, 1'b0);
        send_sample(0, 1'b0);
        wait_idle();

        // linear region with the integral moving, full scale balance
        set_all(4000, 256, 16, 512, 90);
        send_sample(1900, 1'b0);
        send_sample(1950, 1'b0);
        send_sample(2000, 1'b0);
        send_sample(2100, 1'b0);
        send_sample(0, 1'b0);
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_settings();
            tx_steady = (phase == 3);
            rx_steady = (phase == 3) || (phase == 5);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while items keep coming
                if (phase == 1 && n == 30)
                    rx_hold_cycles = 400;
                send_random_item();
            end
            wait_idle();
        end

        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
